FILE: src/sprle_pkg.sv
// Shared types and constants for the subpicture run-length line decoder.
`default_nettype none

package sprle_pkg;

    // Field widths fixed by the stream format
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned COLOR_W = 28;
    localparam int unsigned ACC_W   = 10;
    localparam int unsigned CODE_W  = 14;
    localparam int unsigned CFG_W   = 28;
    localparam int unsigned CFG_AW  = 3;

    // Code termination thresholds after one, two and three nibbles
    localparam logic [CODE_W-1:0] CODE_ONE_MAX   = 14'h0003;
    localparam logic [CODE_W-1:0] CODE_TWO_MAX   = 14'h000f;
    localparam logic [CODE_W-1:0] CODE_THREE_MAX = 14'h003f;

    // Register reset values
    localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd720;
    localparam logic [DIM_W-1:0] COUNT_RESET = 13'd576;

    // Configuration register indexes
    typedef enum logic [CFG_AW-1:0] {
        CFG_COLOR_ZERO  = 3'd0,
        CFG_COLOR_ONE   = 3'd1,
        CFG_COLOR_TWO   = 3'd2,
        CFG_COLOR_THREE = 3'd3,
        CFG_LINE_WIDTH  = 3'd4,
        CFG_LINE_COUNT  = 3'd5
    } sprle_cfg_idx_t;

    // Line decode state carried from nibble to nibble
    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [1:0]       taken;
        logic [DIM_W-1:0] pix_left;
        logic [DIM_W-1:0] lines_done;
    } sprle_line_st_t;

    // Outcome of one nibble
    typedef struct packed {
        logic             done;
        logic [DIM_W-1:0] run_length;
        logic [1:0]       clr;
        logic             eol;
        logic             eoi;
    } sprle_step_res_t;

    // One finished run as it leaves the block
    typedef struct packed {
        logic [DIM_W-1:0]   run_length;
        logic [COLOR_W-1:0] run_color;
        logic               eol;
        logic               eoi;
        logic               last;
    } sprle_run_t;

endpackage

`default_nettype wire

FILE: src/subpicture_rle_line_decoder.sv
// Subpicture run-length line decoder: input register, byte decode, result buffer.
// A taken byte passes through the input register and then the result buffer.
// Throughput: one byte per cycle if m_tready stays high and no byte yields two runs;
//   a two-run byte holds off the next until its first run leaves the result port.
// Reset (aresetn low, synchronous) clears colors, loads width 720, count 576,
//   and empties the line state and both buffers.
`default_nettype none

module subpicture_rle_line_decoder #(
    parameter int unsigned MAX_DIMENSION = 4096
) (
    input  wire         aclk,
    input  wire         aresetn,
    // Configuration writes
    input  wire         cfg_wr_en,
    input  wire [2:0]   cfg_addr,
    input  wire [27:0]  cfg_wdata,
    // Slave side
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire [7:0]   s_tdata,   // [7:0] data_byte
    input  wire         s_tuser,   // [0] mode
    // Master side
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [47:0] m_tdata,   // [12:0] run_length, [40:13] run_color, zero fill
    output logic [1:0]  m_tuser,   // [0] end_of_line, [1] end_of_image
    output logic        m_tlast    // last_for_byte
);
    import sprle_pkg::*;

    localparam logic [DIM_W-1:0] DIM_MAX = DIM_W'(MAX_DIMENSION);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        begin
            r = v;
            if (v == '0) begin
                r = 13'd1;
            end else if (v > DIM_MAX) begin
                r = DIM_MAX;
            end
            return r;
        end
    endfunction

    // Configuration registers
    logic [COLOR_W-1:0] color_zero_reg;
    logic [COLOR_W-1:0] color_one_reg;
    logic [COLOR_W-1:0] color_two_reg;
    logic [COLOR_W-1:0] color_three_reg;
    logic [DIM_W-1:0]   line_width_reg;
    logic [DIM_W-1:0]   line_count_reg;

    // Input register
    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [7:0]         in_byte_reg;

    // Line state
    sprle_line_st_t     line_reg;
    sprle_line_st_t     line_next;
    logic               fin_reg;
    logic               fin_next;

    logic [DIM_W-1:0]   width_eff;
    logic [DIM_W-1:0]   count_eff;
    sprle_line_st_t     st0;
    sprle_line_st_t     st1;
    sprle_step_res_t    res0;
    sprle_step_res_t    res1;
    logic               hit0;
    logic               hit1;
    sprle_run_t         run0;
    sprle_run_t         run1;
    sprle_run_t         load0;
    sprle_run_t         load1;
    logic [1:0]         load_cnt;
    logic               can_load;
    logic               proc;
    sprle_run_t         head;

    function automatic logic [COLOR_W-1:0] pick_color(
        input logic [1:0]         clr,
        input logic [COLOR_W-1:0] c0,
        input logic [COLOR_W-1:0] c1,
        input logic [COLOR_W-1:0] c2,
        input logic [COLOR_W-1:0] c3
    );
        logic [COLOR_W-1:0] r;
        begin
            case (clr)
                2'd0:    r = c0;
                2'd1:    r = c1;
                2'd2:    r = c2;
                default: r = c3;
            endcase
            return r;
        end
    endfunction

    assign width_eff = clamp_dim(line_width_reg);
    assign count_eff = clamp_dim(line_count_reg);

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_zero_reg  <= '0;
            color_one_reg   <= '0;
            color_two_reg   <= '0;
            color_three_reg <= '0;
            line_width_reg  <= WIDTH_RESET;
            line_count_reg  <= COUNT_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_COLOR_ZERO:  color_zero_reg  <= cfg_wdata;
                CFG_COLOR_ONE:   color_one_reg   <= cfg_wdata;
                CFG_COLOR_TWO:   color_two_reg   <= cfg_wdata;
                CFG_COLOR_THREE: color_three_reg <= cfg_wdata;
                CFG_LINE_WIDTH:  line_width_reg  <= cfg_wdata[DIM_W-1:0];
                CFG_LINE_COUNT:  line_count_reg  <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: take a request whenever the held one moves on
    assign proc     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_mode_reg <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // High nibble, then low nibble on the advanced state
    sprle_step u_step_hi (
        .st_i      (line_reg),
        .nib       (in_byte_reg[7:4]),
        .width_eff (width_eff),
        .count_eff (count_eff),
        .st_o      (st0),
        .res       (res0)
    );

    sprle_step u_step_lo (
        .st_i      (st0),
        .nib       (in_byte_reg[3:0]),
        .width_eff (width_eff),
        .count_eff (count_eff),
        .st_o      (st1),
        .res       (res1)
    );

    // Pick the state left behind by this request
    always_comb begin
        line_next = line_reg;
        fin_next  = fin_reg;
        if (in_mode_reg) begin
            line_next.acc        = '0;
            line_next.taken      = '0;
            line_next.pix_left   = width_eff;
            line_next.lines_done = '0;
            fin_next             = 1'b0;
        end else if (!fin_reg) begin
            if (res0.eol) begin
                line_next = st0;
                fin_next  = res0.eoi;
            end else begin
                line_next = st1;
                fin_next  = res1.eoi;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg.acc        <= '0;
            line_reg.taken      <= '0;
            line_reg.pix_left   <= clamp_dim(WIDTH_RESET);
            line_reg.lines_done <= '0;
            fin_reg             <= 1'b0;
        end else if (proc) begin
            line_reg <= line_next;
            fin_reg  <= fin_next;
        end
    end

    // Build up to two runs; drop the low nibble after a line end
    always_comb begin
        hit0 = !in_mode_reg && !fin_reg && res0.done;
        hit1 = !in_mode_reg && !fin_reg && !res0.eol && res1.done;

        run0.run_length = res0.run_length;
        run0.run_color  = pick_color(res0.clr, color_zero_reg, color_one_reg,
                                     color_two_reg, color_three_reg);
        run0.eol        = res0.eol;
        run0.eoi        = res0.eoi;
        run0.last       = !hit1;

        run1.run_length = res1.run_length;
        run1.run_color  = pick_color(res1.clr, color_zero_reg, color_one_reg,
                                     color_two_reg, color_three_reg);
        run1.eol        = res1.eol;
        run1.eoi        = res1.eoi;
        run1.last       = 1'b1;

        load0    = hit0 ? run0 : run1;
        load1    = run1;
        load_cnt = {1'b0, hit0} + {1'b0, hit1};
    end

    sprle_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (proc),
        .load_cnt  (load_cnt),
        .load0     (load0),
        .load1     (load1),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .head      (head)
    );

    assign m_tdata = {7'd0, head.run_color, head.run_length};
    assign m_tuser = {head.eoi, head.eol};
    assign m_tlast = head.last;

endmodule

`default_nettype wire

FILE: src/sprle_step.sv
// One nibble of code assembly, run clipping and line/image accounting.
`default_nettype none

module sprle_step (
    input  wire sprle_pkg::sprle_line_st_t  st_i,
    input  wire [3:0]                       nib,
    input  wire [sprle_pkg::DIM_W-1:0]      width_eff,
    input  wire [sprle_pkg::DIM_W-1:0]      count_eff,
    output sprle_pkg::sprle_line_st_t       st_o,
    output sprle_pkg::sprle_step_res_t      res
);
    import sprle_pkg::*;

    logic [CODE_W-1:0] code;
    logic [2:0]        taken;
    logic              done;
    logic [DIM_W-1:0]  run_ext;
    logic              clip;
    logic [DIM_W-1:0]  lines_inc;

    // Append nibble and decide whether the code is complete
    always_comb begin
        code  = {st_i.acc, nib};
        taken = {1'b0, st_i.taken} + 3'd1;
        done  = ((taken == 3'd1) && (code > CODE_ONE_MAX)) ||
                ((taken == 3'd2) && (code > CODE_TWO_MAX)) ||
                ((taken == 3'd3) && (code > CODE_THREE_MAX)) ||
                (taken >= 3'd4);
        run_ext   = {1'b0, code[CODE_W-1:2]};
        clip      = (run_ext == '0) || (run_ext >= st_i.pix_left);
        lines_inc = st_i.lines_done + 13'd1;
    end

    // Advance the line state
    always_comb begin
        st_o = st_i;
        if (!done) begin
            st_o.acc   = code[ACC_W-1:0];
            st_o.taken = taken[1:0];
        end else begin
            st_o.acc   = '0;
            st_o.taken = '0;
            if (clip) begin
                st_o.pix_left   = width_eff;
                st_o.lines_done = lines_inc;
            end else begin
                st_o.pix_left = st_i.pix_left - run_ext;
            end
        end
    end

    // Describe the run, clipped at line end
    always_comb begin
        res.done       = done;
        res.run_length = clip ? st_i.pix_left : run_ext;
        res.clr        = code[1:0];
        res.eol        = done && clip;
        res.eoi        = done && clip && (lines_inc >= count_eff);
    end

endmodule

`default_nettype wire

FILE: src/sprle_outq.sv
// Two-entry result buffer: one run per cycle out to a ready master side.
`default_nettype none

module sprle_outq (
    input  wire                         aclk,
    input  wire                         aresetn,
    input  wire                         load,
    input  wire [1:0]                   load_cnt,
    input  wire sprle_pkg::sprle_run_t  load0,
    input  wire sprle_pkg::sprle_run_t  load1,
    output logic                        can_load,
    output logic                        out_valid,
    input  wire                         out_ready,
    output sprle_pkg::sprle_run_t       head
);
    import sprle_pkg::*;

    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    sprle_run_t q0_reg;
    sprle_run_t q0_next;
    sprle_run_t q1_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign head      = q0_reg;
    assign pop       = out_valid && out_ready;
    // Accept a new pair when the buffer is empty or empties this cycle
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);

    // Load a fresh pair or shift the second entry forward
    always_comb begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        if (load) begin
            cnt_next = load_cnt;
            q0_next  = load0;
        end else if (pop) begin
            cnt_next = cnt_reg - 2'd1;
            q0_next  = q1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        if (load) begin
            q1_reg <= load1;
        end
    end

endmodule

`default_nettype wire

FILE: src/sprle_checker.sv
// Port-level checks for the subpicture run-length line decoder, bound to the top level.
`default_nettype none

module sprle_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [47:0] m_tdata,
    input wire [1:0]  m_tuser,
    input wire        m_tlast
);

    // Hold a stalled result request
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // Every run covers at least one pixel
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:0] != 13'd0))
        else $error("zero-length run");

    // Image end only on a line end, and a line end closes the byte
    a_eoi: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("image end without line end");

    a_eol: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("run after line end in same byte");

    // No result right after reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind subpicture_rle_line_decoder sprle_checker u_sprle_checker (.*);

`default_nettype wire

FILE: test/tb_top.sv
// Self-checking stream testbench for the subpicture run-length line decoder.
`timescale 1ns / 100ps

module tb_top;
    import sprle_pkg::*;

    localparam logic [2:0]  CFG_UNUSED_IDX = 3'd6;
    localparam logic [12:0] DIM_MAX        = 13'd4096;
    localparam int          DRAIN_CYCLES   = 8;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_addr;
    logic [27:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // [12:0] run_length, [40:13] run_color, zero fill
    logic [1:0]  m_tuser;   // [0] end_of_line, [1] end_of_image
    logic        m_tlast;

    subpicture_rle_line_decoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Decoder shadow: registers and line state
    logic [27:0] palette [4];
    logic [12:0] width_reg;
    logic [12:0] count_reg;
    logic [9:0]  code_acc;
    logic [1:0]  code_nibbles;
    logic [12:0] pix_left;
    logic [12:0] lines_done;
    bit          img_done;

    sprle_run_t  byte_runs [2];
    int          n_byte_runs;
    sprle_run_t  expected_runs [$];
    int          data_bytes_decoded;
    int          mismatches;

    // Stream generator state
    logic [3:0]  nibble_q [$];
    int          gen_left;

    int          send_idle_pct;
    int          recv_idle_pct;

    always #5 aclk = ~aclk;

    function automatic logic [12:0] effective_dim(logic [12:0] v);
        if (v == 13'd0)
            return 13'd1;
        if (v > DIM_MAX)
            return DIM_MAX;
        return v;
    endfunction

    // Feed one nibble into the code builder; return 1 when the line closes
    function automatic bit decode_nibble(logic [3:0] nib);
        logic [13:0] v;
        int          taken;
        bit          done;
        sprle_run_t  r;
        v = ({4'b0, code_acc} << 4) | {10'b0, nib};
        taken = code_nibbles + 1;
        done = (taken == 1 && v > CODE_ONE_MAX) || (taken == 2 && v > CODE_TWO_MAX) ||
               (taken == 3 && v > CODE_THREE_MAX) || taken >= 4;
        if (!done) begin
            code_acc = v[9:0];
            code_nibbles = taken[1:0];
            return 1'b0;
        end
        code_acc = '0;
        code_nibbles = '0;
        r.run_length = {1'b0, v[13:2]};
        r.run_color = palette[v[1:0]];
        r.eol = 1'b0;
        r.eoi = 1'b0;
        r.last = 1'b0;
        // Zero count fills the line; an overlong run is clipped to it
        if (r.run_length == 13'd0 || r.run_length >= pix_left) begin
            r.run_length = pix_left;
            r.eol = 1'b1;
            lines_done = lines_done + 13'd1;
            if (lines_done >= effective_dim(count_reg)) begin
                r.eoi = 1'b1;
                img_done = 1'b1;
            end
            pix_left = effective_dim(width_reg);
        end else begin
            pix_left = pix_left - r.run_length;
        end
        byte_runs[n_byte_runs] = r;
        n_byte_runs++;
        return r.eol;
    endfunction

    // Work out the runs that one accepted request causes
    function automatic void predict_byte_runs(bit mode, logic [7:0] data);
        n_byte_runs = 0;
        if (mode) begin
            code_acc = '0;
            code_nibbles = '0;
            pix_left = effective_dim(width_reg);
            lines_done = '0;
            img_done = 1'b0;
            return;
        end
        if (img_done)
            return;
        data_bytes_decoded++;
        // Line end on the high nibble drops the low one
        if (!decode_nibble(data[7:4]))
            void'(decode_nibble(data[3:0]));
        for (int i = 0; i < n_byte_runs; i++) begin
            if (i == n_byte_runs - 1)
                byte_runs[i].last = 1'b1;
            expected_runs.push_back(byte_runs[i]);
        end
    endfunction

    task automatic send_request(bit mode, logic [7:0] data);
        @(negedge aclk);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do
                @(negedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= data;
        do
            @(posedge aclk);
        while (!s_tready);
        predict_byte_runs(mode, data);
    endtask

    // Hold off the sender until every pending run is out and the block is quiet
    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [27:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            CFG_COLOR_ZERO, CFG_COLOR_ONE, CFG_COLOR_TWO, CFG_COLOR_THREE:
                palette[idx[1:0]] = value;
            CFG_LINE_WIDTH: width_reg = value[12:0];
            CFG_LINE_COUNT: count_reg = value[12:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic note_mismatch(string field, longint want, longint got);
        if (mismatches < 10)
            $display("%0t: %s expected 0x%0h got 0x%0h", $realtime, field, want, got);
        mismatches++;
    endtask

    // Compare each delivered run with the oldest prediction
    always @(posedge aclk) begin : check_runs
        sprle_run_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_runs.size() == 0) begin
                note_mismatch("unexpected run, run_length", 0, m_tdata[12:0]);
            end else begin
                want = expected_runs.pop_front();
                if (m_tdata[12:0] !== want.run_length)
                    note_mismatch("run_length", want.run_length, m_tdata[12:0]);
                if (m_tdata[40:13] !== want.run_color)
                    note_mismatch("run_color", want.run_color, m_tdata[40:13]);
                if (m_tuser[0] !== want.eol)
                    note_mismatch("end_of_line", want.eol, m_tuser[0]);
                if (m_tuser[1] !== want.eoi)
                    note_mismatch("end_of_image", want.eoi, m_tuser[1]);
                if (m_tlast !== want.last)
                    note_mismatch("last_for_byte", want.last, m_tlast);
            end
        end
    end

    // Random back-pressure on the result side
    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Append the nibbles of one code, in its shortest form
    function automatic void push_code(logic [11:0] run, logic [1:0] clr);
        logic [9:0] v;
        v = {run[7:0], clr};
        if (v <= CODE_TWO_MAX[9:0]) begin
            nibble_q.push_back(v[3:0]);
        end else if (v <= CODE_THREE_MAX[9:0]) begin
            nibble_q.push_back(v[7:4]);
            nibble_q.push_back(v[3:0]);
        end else if (v <= 10'h0ff) begin
            nibble_q.push_back(4'h0);
            nibble_q.push_back(v[7:4]);
            nibble_q.push_back(v[3:0]);
        end else begin
            nibble_q.push_back(4'h0);
            nibble_q.push_back({2'b00, v[9:8]});
            nibble_q.push_back(v[7:4]);
            nibble_q.push_back(v[3:0]);
        end
    endfunction

    // Pick the next code of a well-formed line and queue its nibbles
    function automatic void queue_next_code();
        int         pick;
        int         run;
        int         max_run;
        bit         ends_line;
        logic [1:0] clr;
        clr = 2'($urandom_range(3));
        pick = $urandom_range(99);
        ends_line = 1'b1;
        if (pick < 10) begin
            // fill the rest of the line
            nibble_q.push_back(4'h0);
            nibble_q.push_back(4'h0);
            nibble_q.push_back(4'h0);
            nibble_q.push_back({2'b00, clr});
        end else if ((pick < 22 || gen_left == 1) && gen_left <= 255) begin
            // land exactly on or run past the line end
            run = $urandom_range(gen_left, (gen_left + 20 > 255) ? 255 : gen_left + 20);
            push_code(12'(run), clr);
        end else begin
            ends_line = 1'b0;
            max_run = (gen_left - 1 > 255) ? 255 : gen_left - 1;
            pick = $urandom_range(99);
            if (pick < 50)
                run = $urandom_range(1, 3);
            else if (pick < 75)
                run = $urandom_range(4, 15);
            else if (pick < 90)
                run = $urandom_range(16, 63);
            else
                run = $urandom_range(64, 255);
            if (run > max_run)
                run = $urandom_range(1, max_run);
            push_code(12'(run), clr);
            gen_left -= run;
        end
        // Pad the byte when the line ends on a high nibble
        if (ends_line) begin
            gen_left = effective_dim(width_reg);
            if (nibble_q.size() % 2 != 0)
                nibble_q.push_back(4'($urandom_range(15)));
        end
    endfunction

    task automatic start_image();
        send_request(1'b1, 8'($urandom_range(255)));
        nibble_q.delete();
        gen_left = effective_dim(width_reg);
    endtask

    task automatic randomize_config();
        int          pick;
        logic [27:0] c;
        for (int i = 0; i < 4; i++) begin
            pick = $urandom_range(3);
            c = (pick == 0) ? 28'h0 : (pick == 1) ? 28'hfffffff : 28'($urandom);
            cfg_write(3'(i), c);
        end
        pick = $urandom_range(99);
        if (pick < 80)
            cfg_write(CFG_LINE_WIDTH, 28'($urandom_range(1, 24)));
        else if (pick < 92)
            cfg_write(CFG_LINE_WIDTH, 28'($urandom_range(25, 300)));
        else if (pick < 96)
            cfg_write(CFG_LINE_WIDTH, 28'd4096);
        else if (pick < 98)
            cfg_write(CFG_LINE_WIDTH, 28'd0);
        else
            cfg_write(CFG_LINE_WIDTH, 28'h1fff);
        pick = $urandom_range(99);
        if (pick < 70)
            cfg_write(CFG_LINE_COUNT, 28'($urandom_range(1, 4)));
        else if (pick < 90)
            cfg_write(CFG_LINE_COUNT, 28'($urandom_range(5, 20)));
        else if (pick < 95)
            cfg_write(CFG_LINE_COUNT, 28'd4096);
        else if (pick < 98)
            cfg_write(CFG_LINE_COUNT, 28'd0);
        else
            cfg_write(CFG_LINE_COUNT, 28'h1fff);
    endtask

    // One step of the random stream: a data byte, or noise, or a new image
    task automatic stream_step();
        logic [3:0] hi;
        logic [3:0] lo;
        if (img_done) begin
            // bytes after image end are dropped by the block
            if ($urandom_range(99) < 30)
                repeat ($urandom_range(1, 2)) send_request(1'b0, 8'($urandom_range(255)));
            start_image();
        end else if ($urandom_range(99) < 6) begin
            send_request(1'($urandom_range(1)), 8'($urandom_range(255)));
            start_image();
        end else begin
            while (nibble_q.size() < 2)
                queue_next_code();
            hi = nibble_q.pop_front();
            lo = nibble_q.pop_front();
            send_request(1'b0, {hi, lo});
        end
    endtask

    task automatic test_directed();
        wait_drained();
        cfg_write(CFG_COLOR_ZERO, 28'h0000000);
        cfg_write(CFG_COLOR_ONE, 28'hfffffff);
        cfg_write(CFG_COLOR_TWO, 28'h5a5a5a5);
        cfg_write(CFG_COLOR_THREE, 28'ha5a5a5a);
        cfg_write(CFG_LINE_WIDTH, 28'd8);
        cfg_write(CFG_LINE_COUNT, 28'd2);
        send_request(1'b1, 8'h00);
        // one-, two- and four-nibble codes, clip on a high nibble
        send_request(1'b0, 8'h45);
        send_request(1'b0, 8'h17);
        send_request(1'b0, 8'hf0);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'h0e);
        // narrow the line mid-way; the open line keeps its old width
        wait_drained();
        cfg_write(CFG_LINE_WIDTH, 28'd5);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'h03);
        send_request(1'b0, 8'hff);
        send_request(1'b1, 8'hff);
        // three-nibble code past the line end, then a clip on a low nibble
        send_request(1'b0, 8'h05);
        send_request(1'b0, 8'h21);
        send_request(1'b0, 8'hff);
        send_request(1'b1, 8'h00);
        wait_drained();
        cfg_write(CFG_LINE_WIDTH, 28'd4096);
        cfg_write(CFG_LINE_COUNT, 28'd4096);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'h01);
        send_request(1'b0, 8'h3f);
        send_request(1'b0, 8'h01);
        send_request(1'b0, 8'h23);
        // lower the count to the lines already done
        wait_drained();
        cfg_write(CFG_LINE_COUNT, 28'd1);
        send_request(1'b0, 8'h00);
        send_request(1'b0, 8'h02);
        send_request(1'b1, 8'h5a);
        // out-of-range sizes saturate; an unused index is ignored
        wait_drained();
        cfg_write(CFG_LINE_WIDTH, 28'd0);
        cfg_write(CFG_LINE_COUNT, 28'h1fff);
        cfg_write(CFG_UNUSED_IDX, 28'hfffffff);
        send_request(1'b0, 8'h40);
        send_request(1'b0, 8'h8c);
        start_image();
    endtask

    task automatic test_random_stream(int n_bytes, int s_pct, int r_pct);
        int target;
        int chunk_end;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        target = data_bytes_decoded + n_bytes;
        while (data_bytes_decoded < target) begin
            wait_drained();
            randomize_config();
            chunk_end = data_bytes_decoded + $urandom_range(80, 160);
            while (data_bytes_decoded < chunk_end && data_bytes_decoded < target)
                stream_step();
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        for (int i = 0; i < 4; i++)
            palette[i] = '0;
        width_reg = WIDTH_RESET;
        count_reg = COUNT_RESET;
        code_acc = '0;
        code_nibbles = '0;
        pix_left = WIDTH_RESET;
        lines_done = '0;
        img_done = 1'b0;
        n_byte_runs = 0;
        data_bytes_decoded = 0;
        mismatches = 0;
        gen_left = WIDTH_RESET;
        send_idle_pct = 21;
        recv_idle_pct = 73;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // image starts and dropped bytes do not add to the decoded data bytes
        test_directed();
        test_random_stream(450, 21, 73);
        test_random_stream(445, 73, 21);
        test_random_stream(445, 0, 0);

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

endmodule

FILE: filelist.f
src/sprle_pkg.sv
src/sprle_step.sv
src/sprle_outq.sv
src/subpicture_rle_line_decoder.sv
src/sprle_checker.sv
test/tb_top.sv
